// ===== sv/sha512_pkg.sv =====
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int WordW = 64;
  localparam int BlockWords = 16;
  localparam int RoundCount = 80;
  localparam int DigestWords = 8;
  localparam int LengthWordAt = 14;

  typedef logic [WordW-1:0] word_t;

  localparam word_t IV [DigestWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [RoundCount] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ===== sv/sha512_if.sv =====
`timescale 1ns / 1ps
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_item;
  modport source (output valid, data_word, byte_count, last_item, input ready);
  modport sink (input valid, data_word, byte_count, last_item, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha512_ram.sv =====
`timescale 1ns / 1ps
module sha512_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sha512_stream_hasher.sv =====
// an item of n bytes holds the input, one ram read and one write per byte
// a filled block is compressed in 80 rounds, one a cycle, then one fold into the chain value
// a last item pads byte by byte up to byte 112, writes the length in two words, then
// compresses, plus one more block when the pad crosses a block; 8 transfers follow
// sequential hasher, paced by the byte-wise ram read-modify-write and the compression loop
// reset (synchronous): chain value to the initial hash, byte count and fill to zero
`timescale 1ns / 1ps
module sha512_stream_hasher
  import sha512_pkg::*;
(
  input logic clk,
  input logic rst,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_ABSORB, S_PAD, S_LEN, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t      state;
  word_t       chain [DigestWords];
  word_t       va, vb, vc, vd, ve, vf, vg, vh;
  logic [6:0]  fill;
  logic [127:0] msg_bytes;
  logic [6:0]  round;
  logic [63:0] hold_data;
  logic [3:0]  hold_cnt;
  logic [3:0]  byte_i;
  logic        hold_last;
  logic        padding;
  logic        final_pass;
  logic [2:0]  emit_i;
  word_t       wcur;

  // block buffer ram
  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  word_t       ram_wdata, ram_rdata;

  sha512_ram #(.Width(WordW), .Depth(BlockWords)) u_buf (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // schedule taps kept in a 16-deep shift line for the rounds past 15
  word_t win [BlockWords];
  word_t w_new, w2, w15, t1, t2, ram_merge;
  logic [2:0] bpos;
  logic [5:0] sh;

  assign w2  = win[14];
  assign w15 = win[1];
  always_comb begin
    w_new = (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6)) + win[9]
          + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + win[0];
    wcur = (round < 7'(BlockWords)) ? ram_rdata : w_new;
    t1 = vh + (rotr(ve, 14) ^ rotr(ve, 18) ^ rotr(ve, 41)) + ((ve & vf) ^ (~ve & vg))
       + RoundK[round] + wcur;
    t2 = (rotr(va, 28) ^ rotr(va, 34) ^ rotr(va, 39)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  // byte merge: the byte goes into the current word, read from the ram at fill>>3
  logic [7:0] cur_byte;
  logic [127:0] bits;
  assign bits = msg_bytes << 3;
  assign bpos = fill[2:0];
  assign sh = 6'd56 - {bpos, 3'b000};
  always_comb begin
    cur_byte = 8'h00;
    unique case (state)
      S_ABSORB: cur_byte = hold_data[63:56];
      default:  cur_byte = 8'h00;
    endcase
    ram_merge = (ram_rdata & ~(word_t'(8'hFF) << sh)) | (word_t'(cur_byte) << sh);
  end

  logic rd_ok;
  assign in_ch.ready = (state == S_IDLE) && !rst;

  logic [6:0] fill_inc;
  assign fill_inc = fill + 7'd1;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = fill[6:3];
    ram_wdata = ram_merge;
    ram_raddr = fill[6:3];
    unique case (state)
      S_ABSORB: begin
        ram_we = rd_ok;
        ram_raddr = rd_ok ? fill_inc[6:3] : fill[6:3];
      end
      S_PAD: begin
        ram_we = rd_ok;
        ram_raddr = rd_ok ? fill_inc[6:3] : fill[6:3];
        ram_wdata = hold_last ? (ram_rdata & ~(word_t'(8'hFF) << sh)) | (word_t'(8'h80) << sh)
                              : ram_merge;
      end
      S_LEN: begin
        ram_we = 1'b1;
        ram_waddr = fill[3:0] == 4'd0 ? 4'(LengthWordAt) : 4'(LengthWordAt + 1);
        ram_wdata = fill[3:0] == 4'd0 ? bits[127:64] : bits[63:0];
      end
      S_ROUND: ram_raddr = 4'(round + 7'd1);
      default: ram_raddr = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      msg_bytes <= '0;
      for (int k = 0; k < DigestWords; k++) chain[k] <= IV[k];
      rd_ok <= 1'b0;
      out_ch.valid <= 1'b0;
      final_pass <= 1'b0;
      padding <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_ok <= 1'b0;
          if (in_ch.valid) begin
            hold_data <= in_ch.data_word;
            hold_cnt <= (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
            hold_last <= in_ch.last_item;
            byte_i <= '0;
            state <= S_ABSORB;
          end
        end
        S_ABSORB: begin
          if (byte_i == hold_cnt) begin
            rd_ok <= 1'b0;
            if (hold_last) begin
              padding <= 1'b1;
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            hold_data <= hold_data << 8;
            byte_i <= byte_i + 4'd1;
            msg_bytes <= msg_bytes + 128'd1;
            fill <= fill_inc;
            if (fill == 7'h7F) begin
              final_pass <= 1'b0;
              round <= '0;
              {va, vb, vc, vd, ve, vf, vg, vh} <= {chain[0], chain[1], chain[2], chain[3],
                                                  chain[4], chain[5], chain[6], chain[7]};
              state <= S_ROUND;
            end
          end
        end
        S_PAD: begin
          // hold_last marks the 0x80 byte still pending
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            hold_last <= 1'b0;
            fill <= fill_inc;
            if (fill_inc == 7'd0) begin
              final_pass <= 1'b0;
              round <= '0;
              {va, vb, vc, vd, ve, vf, vg, vh} <= {chain[0], chain[1], chain[2], chain[3],
                                                  chain[4], chain[5], chain[6], chain[7]};
              state <= S_ROUND;
            end else if (fill_inc == 7'd112) begin
              fill <= '0;
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (fill[3:0] == 4'd0) begin
            fill <= 7'd1;
          end else begin
            fill <= '0;
            final_pass <= 1'b1;
            round <= '0;
            {va, vb, vc, vd, ve, vf, vg, vh} <= {chain[0], chain[1], chain[2], chain[3],
                                                chain[4], chain[5], chain[6], chain[7]};
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int k = 0; k < BlockWords - 1; k++) win[k] <= win[k+1];
          win[BlockWords-1] <= wcur;
          {va, vb, vc, vd, ve, vf, vg, vh} <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
          round <= round + 7'd1;
          if (round == 7'(RoundCount - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          chain[0] <= chain[0] + va; chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc; chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve; chain[5] <= chain[5] + vf;
          chain[6] <= chain[6] + vg; chain[7] <= chain[7] + vh;
          rd_ok <= 1'b0;
          if (final_pass) begin
            emit_i <= '0;
            state <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_ABSORB;
          end
        end
        S_EMIT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.digest_word <= chain[emit_i];
            out_ch.word_index <= emit_i;
            out_ch.last_word <= (emit_i == 3'(DigestWords - 1));
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            emit_i <= emit_i + 3'd1;
            if (out_ch.last_word) begin
              for (int k = 0; k < DigestWords; k++) chain[k] <= IV[k];
              msg_bytes <= '0;
              fill <= '0;
              final_pass <= 1'b0;
              padding <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_EMIT) else $error("result outside emit");
  assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> round < 7'(RoundCount)) else $error("round overrun");
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("input taken while emitting");
endmodule
